[hw/rtl/bubble_sort_array_engine_unit_macros.svh]
`ifndef BUBBLE_SORT_ARRAY_ENGINE_UNIT_MACROS_SVH
`define BUBBLE_SORT_ARRAY_ENGINE_UNIT_MACROS_SVH

// Implication checked on every clock edge, quiet during reset.
`define BSAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Plain state invariant, quiet during reset.
`define BSAE_INVARIANT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`endif

[hw/rtl/bsae_pkg.sv]
package bsae_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 6;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_DISPLAY = 2'd1;
  localparam logic [1:0] OP_SORT    = 2'd2;
  localparam logic [1:0] OP_DELETE  = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BADPOS = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_EMPTY  = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_ROT,
    CELL_SORT,
    CELL_DEL
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e        cmd;
    logic [POS_W-1:0] pos;
    logic             parity;
  } cell_ctrl_t;

endpackage

[hw/rtl/bsae_cell.sv]
module bsae_cell import bsae_pkg::*; #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic [CNT_W-1:0]         count_i,
  input  logic signed [DATA_W-1:0] load_i,
  input  logic signed [DATA_W-1:0] left_i,
  input  logic signed [DATA_W-1:0] right_i,
  output logic signed [DATA_W-1:0] val_o
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_N = CNT_W'(IDX + 1);
  localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

  logic signed [DATA_W-1:0] val_q, val_d;
  logic                     pair_right, pair_left;

  // pair_right: this cell is the lower half of a compare pair in this phase
  assign pair_right = (IDX_C[0] == ctrl_i.parity) && (IDX_N < count_i);
  assign pair_left  = (IDX != 0) && (IDX_C[0] != ctrl_i.parity) && (IDX_C < count_i);

  always_comb begin
    val_d = val_q;
    case (ctrl_i.cmd)
      CELL_LOAD: begin
        if (IDX_C == count_i) val_d = load_i;
      end
      CELL_ROT: val_d = right_i;
      CELL_SORT: begin
        // keep the smaller on the left, the larger on the right
        if (pair_right && (val_q > right_i)) val_d = right_i;
        else if (pair_left && (left_i > val_q)) val_d = left_i;
      end
      CELL_DEL: begin
        if ((IDX_P >= ctrl_i.pos) && (IDX_N < count_i)) val_d = right_i;
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

[hw/rtl/bubble_sort_array_engine_unit.sv]
// Load and delete: the result strobes in the cycle after the start transfer.
// Display: busy while the chain rotates once per cycle for a full turn; the elements leave
// in order from element 0 and the last result is marked by last_o.
// Sort: one odd-even compare-exchange phase over the cell chain per cycle until the array is sorted.
// Results cannot be stalled by the receiver. Reset clears the count and the sequencer;
// the element cells are not reset.
module bubble_sort_array_engine_unit import bsae_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode_i,
  input  logic                     first_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  output logic                     strobe_o,
  output logic signed [DATA_W-1:0] data_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  `include "bubble_sort_array_engine_unit_macros.svh"

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DISP = 2'd1;
  localparam logic [1:0] ST_SORT = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         eff_count;
  logic                     strobe_q, strobe_d;
  logic signed [DATA_W-1:0] data_q, data_d;
  logic [1:0]               status_q, status_d;
  logic                     last_q, last_d;
  logic                     accept;
  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic signed [DATA_W-1:0] removed;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bsae_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (eff_count),
      .load_i  (value_i),
      .left_i  (cell_val[(i + CAPACITY - 1) % CAPACITY]),
      .right_i (cell_val[(i + 1) % CAPACITY]),
      .val_o   (cell_val[i])
    );
  end

  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (POS_W'(i) == position_i) removed = removed | cell_val[i];
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    count_d     = count_q;
    eff_count   = count_q;
    ctrl.cmd    = CELL_HOLD;
    ctrl.pos    = position_i;
    ctrl.parity = cnt_q[0];
    strobe_d    = 1'b0;
    data_d      = '0;
    status_d    = STAT_OK;
    last_d      = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_LOAD: begin
              strobe_d = 1'b1;
              if (first_i) eff_count = '0;
              count_d = eff_count;
              if (eff_count >= CNT_W'(CAPACITY)) begin
                status_d = STAT_FULL;
              end else begin
                ctrl.cmd = CELL_LOAD;
                count_d  = eff_count + 1'b1;
              end
            end
            OP_DISPLAY: begin
              if (count_q == '0) begin
                strobe_d = 1'b1;
                status_d = STAT_EMPTY;
              end else begin
                state_d = ST_DISP;
                cnt_d   = '0;
              end
            end
            OP_SORT: begin
              if (count_q == '0) begin
                strobe_d = 1'b1;
              end else begin
                state_d = ST_SORT;
                cnt_d   = '0;
              end
            end
            OP_DELETE: begin
              strobe_d = 1'b1;
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else if (8'(position_i) >= 8'(count_q)) begin
                status_d = STAT_BADPOS;
              end else begin
                ctrl.cmd = CELL_DEL;
                data_d   = removed;
                count_d  = count_q - 1'b1;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_DISP: begin
        // rotate the whole chain; after CAPACITY steps it is back in place
        ctrl.cmd = CELL_ROT;
        if (cnt_q < count_q) begin
          strobe_d = 1'b1;
          data_d   = cell_val[0];
          last_d   = (cnt_q == count_q - 1'b1);
        end
        if (cnt_q == CNT_W'(CAPACITY - 1)) state_d = ST_IDLE;
        else cnt_d = cnt_q + 1'b1;
      end
      ST_SORT: begin
        ctrl.cmd = CELL_SORT;
        if (cnt_q == count_q - 1'b1) begin
          strobe_d = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q   <= data_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign strobe_o = strobe_q;
  assign data_o   = data_q;
  assign status_o = status_q;
  assign last_o   = last_q;

  `BSAE_INVARIANT(a_count_bound, count_q <= CNT_W'(CAPACITY), "element count above capacity")
  `BSAE_ASSERT(a_mid_busy, (strobe_o && !last_o) |-> busy, "non-final result outside display")
  `BSAE_ASSERT(a_err_last, (strobe_o && (status_o != STAT_OK)) |-> last_o, "error result not last")
  `BSAE_ASSERT(a_start_resp, (start && !busy) |=> (strobe_o || busy), "start without response")

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import bsae_pkg::*;

  localparam int unsigned CAP = 64;
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct {
    logic [1:0]               opcode;
    logic                     first;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    int unsigned              idle_pct;
  } array_cmd_t;

  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic                     last;
  } readout_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               opcode_i = OP_LOAD;
  logic                     first_i = 1'b0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic [POS_W-1:0]         position_i = '0;
  logic                     strobe_o;
  logic signed [DATA_W-1:0] data_o;
  logic [1:0]               status_o;
  logic                     last_o;

  array_cmd_t cmd_queue[$];
  readout_t   awaited_readouts[$];

  // shadow copy of the array contents
  logic signed [DATA_W-1:0] elem_mem [CAP];
  int unsigned              elem_cnt = 0;
  // element count as seen by the stimulus generator
  int unsigned              gen_cnt = 0;

  bit          took = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned err_cnt = 0;

  bubble_sort_array_engine_unit #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .opcode_i  (opcode_i),
    .first_i   (first_i),
    .value_i   (value_i),
    .position_i(position_i),
    .strobe_o  (strobe_o),
    .data_o    (data_o),
    .status_o  (status_o),
    .last_o    (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic readout_t mk_readout(logic signed [DATA_W-1:0] data, logic [1:0] status,
                                          logic last);
    readout_t r;
    r.data   = data;
    r.status = status;
    r.last   = last;
    return r;
  endfunction

  task automatic apply_array_op(input array_cmd_t c);
    logic signed [DATA_W-1:0] tmp;
    int unsigned              n;
    case (c.opcode)
      OP_LOAD: begin
        if (c.first) elem_cnt = 0;
        if (elem_cnt >= CAP) begin
          awaited_readouts.push_back(mk_readout('0, STAT_FULL, 1'b1));
        end else begin
          elem_mem[elem_cnt] = c.value;
          elem_cnt++;
          awaited_readouts.push_back(mk_readout('0, STAT_OK, 1'b1));
        end
      end
      OP_DISPLAY: begin
        if (elem_cnt == 0) begin
          awaited_readouts.push_back(mk_readout('0, STAT_EMPTY, 1'b1));
        end else begin
          for (int k = 0; k < elem_cnt; k++)
            awaited_readouts.push_back(mk_readout(elem_mem[k], STAT_OK, k == elem_cnt - 1));
        end
      end
      OP_SORT: begin
        n = elem_cnt;
        for (int p = 0; p < n; p++) begin
          for (int k = 0; k + 1 < n - p; k++) begin
            if (elem_mem[k] > elem_mem[k+1]) begin
              tmp           = elem_mem[k];
              elem_mem[k]   = elem_mem[k+1];
              elem_mem[k+1] = tmp;
            end
          end
        end
        awaited_readouts.push_back(mk_readout('0, STAT_OK, 1'b1));
      end
      default: begin
        if (elem_cnt == 0) begin
          awaited_readouts.push_back(mk_readout('0, STAT_EMPTY, 1'b1));
        end else if (c.position >= elem_cnt) begin
          awaited_readouts.push_back(mk_readout('0, STAT_BADPOS, 1'b1));
        end else begin
          tmp = elem_mem[c.position];
          for (int k = c.position; k + 1 < elem_cnt; k++) elem_mem[k] = elem_mem[k+1];
          elem_cnt--;
          awaited_readouts.push_back(mk_readout(tmp, STAT_OK, 1'b1));
        end
      end
    endcase
  endtask

  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return $signed($urandom_range(0, 16)) - 8;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic queue_cmd(input logic [1:0] op, input logic first, input logic [DATA_W-1:0] value,
                           input logic [POS_W-1:0] pos, input int unsigned idle_pct);
    array_cmd_t c;
    c.opcode   = op;
    c.first    = first;
    c.value    = value;
    c.position = pos;
    c.idle_pct = idle_pct;
    cmd_queue.push_back(c);
    if (op == OP_LOAD) begin
      if (first) gen_cnt = 0;
      if (gen_cnt < CAP) gen_cnt++;
    end else if (op == OP_DELETE && pos < gen_cnt) begin
      gen_cnt--;
    end
  endtask

  // driver: hold the item until its transfer, then pick the next one or idle
  always @(negedge clk_i) begin
    if (rst_ni && (!start || took)) begin
      took = 1'b0;
      if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= cmd_queue[0].idle_pct) begin
        start      <= 1'b1;
        opcode_i   <= cmd_queue[0].opcode;
        first_i    <= cmd_queue[0].first;
        value_i    <= cmd_queue[0].value;
        position_i <= cmd_queue[0].position;
      end else begin
        start      <= 1'b0;
        opcode_i   <= 2'($urandom_range(0, 3));
        first_i    <= 1'($urandom_range(0, 1));
        value_i    <= $urandom;
        position_i <= POS_W'($urandom_range(0, 63));
      end
    end
  end

  // monitor: track transfers, check results, watch for a hang
  always @(posedge clk_i) begin
    readout_t exp_r;
    if (rst_ni) begin
      quiet_cycles++;
      if (start && !busy) begin
        took         = 1'b1;
        quiet_cycles = 0;
        apply_array_op(cmd_queue.pop_front());
      end
      if (strobe_o) begin
        quiet_cycles = 0;
        if (awaited_readouts.size() == 0) begin
          $display("%0t: unexpected result data=%0d status=%0d last=%0b", $time, data_o,
                   status_o, last_o);
          err_cnt++;
        end else begin
          exp_r = awaited_readouts.pop_front();
          if (data_o !== exp_r.data) begin
            $display("%0t: data mismatch expected %0d actual %0d", $time, exp_r.data, data_o);
            err_cnt++;
          end
          if (status_o !== exp_r.status) begin
            $display("%0t: status mismatch expected %0d actual %0d", $time, exp_r.status,
                     status_o);
            err_cnt++;
          end
          if (last_o !== exp_r.last) begin
            $display("%0t: last mismatch expected %0b actual %0b", $time, exp_r.last, last_o);
            err_cnt++;
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned      roll;
    int unsigned      idle;
    logic [POS_W-1:0] pos;

    // directed: empty array, extremes, duplicates, bad positions, delete at both ends
    queue_cmd(OP_DISPLAY, 1'b0, '0, '0, 17);
    queue_cmd(OP_DELETE, 1'b0, '0, 6'd0, 17);
    queue_cmd(OP_SORT, 1'b0, '0, '0, 17);
    queue_cmd(OP_LOAD, 1'b1, 32'h7fff_ffff, '0, 17);
    queue_cmd(OP_LOAD, 1'b0, 32'h8000_0000, '0, 17);
    queue_cmd(OP_LOAD, 1'b0, 32'h0000_0000, '0, 17);
    queue_cmd(OP_LOAD, 1'b0, 32'hffff_ffff, '0, 17);
    queue_cmd(OP_LOAD, 1'b0, 32'h0000_0001, '0, 17);
    queue_cmd(OP_LOAD, 1'b0, 32'h7fff_ffff, '0, 17);
    queue_cmd(OP_DISPLAY, 1'b0, '0, '0, 17);
    queue_cmd(OP_SORT, 1'b1, 32'hffff_ffff, 6'd63, 17);
    queue_cmd(OP_DISPLAY, 1'b0, '0, '0, 17);
    queue_cmd(OP_DELETE, 1'b0, '0, 6'd63, 17);
    queue_cmd(OP_DELETE, 1'b0, '0, 6'd6, 17);
    queue_cmd(OP_DELETE, 1'b0, '0, 6'd5, 17);
    queue_cmd(OP_DELETE, 1'b0, '0, 6'd0, 17);
    queue_cmd(OP_DELETE, 1'b0, '0, 6'd1, 17);
    queue_cmd(OP_DISPLAY, 1'b0, '0, '0, 17);
    queue_cmd(OP_LOAD, 1'b1, 32'd5, '0, 17);
    queue_cmd(OP_DELETE, 1'b0, '0, 6'd0, 17);
    queue_cmd(OP_DISPLAY, 1'b1, 32'hffff_ffff, 6'd63, 17);
    queue_cmd(OP_LOAD, 1'b0, 32'h5555_5555, 6'd21, 17);
    queue_cmd(OP_LOAD, 1'b1, 32'haaaa_aaaa, 6'd42, 17);
    queue_cmd(OP_DISPLAY, 1'b0, '0, '0, 17);

    for (int ph = 0; ph < 3; ph++) begin
      idle = (ph == 0) ? 17 : (ph == 1) ? 76 : 0;
      // fill past capacity, then work on the full array
      queue_cmd(OP_LOAD, 1'b1, rand_word(), POS_W'($urandom_range(0, 63)), idle);
      repeat (CAP + 1)
        queue_cmd(OP_LOAD, 1'b0, rand_word(), POS_W'($urandom_range(0, 63)), idle);
      queue_cmd(OP_DISPLAY, 1'($urandom_range(0, 1)), $urandom, POS_W'($urandom_range(0, 63)),
                idle);
      queue_cmd(OP_SORT, 1'($urandom_range(0, 1)), $urandom, POS_W'($urandom_range(0, 63)),
                idle);
      queue_cmd(OP_DISPLAY, 1'($urandom_range(0, 1)), $urandom, POS_W'($urandom_range(0, 63)),
                idle);
      queue_cmd(OP_DELETE, 1'b0, $urandom, 6'd63, idle);
      repeat (80) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          queue_cmd(OP_LOAD, 1'b1, rand_word(), POS_W'($urandom_range(0, 63)), idle);
        end else if (roll < 40) begin
          queue_cmd(OP_LOAD, 1'b0, rand_word(), POS_W'($urandom_range(0, 63)), idle);
        end else if (roll < 55) begin
          queue_cmd(OP_DISPLAY, 1'($urandom_range(0, 1)), $urandom,
                    POS_W'($urandom_range(0, 63)), idle);
        end else if (roll < 68) begin
          queue_cmd(OP_SORT, 1'($urandom_range(0, 1)), $urandom,
                    POS_W'($urandom_range(0, 63)), idle);
        end else begin
          if (gen_cnt != 0 && $urandom_range(0, 3) != 0)
            pos = POS_W'($urandom_range(0, gen_cnt - 1));
          else pos = POS_W'($urandom_range(0, 63));
          queue_cmd(OP_DELETE, 1'($urandom_range(0, 1)), $urandom, pos, idle);
        end
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_queue.size() != 0 || awaited_readouts.size() != 0) @(posedge clk_i);
    // let any stray result show up
    repeat (CAP + 8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/bsae_pkg.sv
hw/rtl/bsae_cell.sv
hw/rtl/bubble_sort_array_engine_unit.sv
verif/testbench.sv
